FILE: hdl/multi_slot_repeat_timer_unit_assert.svh
// Assertion macros shared by the timer table checker.
`ifndef MULTI_SLOT_REPEAT_TIMER_UNIT_ASSERT_SVH
`define MULTI_SLOT_REPEAT_TIMER_UNIT_ASSERT_SVH

// The property must hold in the same cycle as its trigger.
`define MSRT_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The property must hold in the cycle after its trigger.
`define MSRT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hdl/mrt_pkg.sv
// Shared types and constants of the timer table.
`timescale 1ns / 1ps

package mrt_pkg;

   localparam int MAX_SLOTS = 16;
   localparam int SLOT_COUNT_DEF = 16;

   localparam int OP_W = 2;
   localparam int TIME_W = 32;
   localparam int REP_W = 16;
   localparam int TAG_W = 32;
   localparam int HANDLE_W = 4;
   localparam int KIND_W = 2;

   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIRED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DONE = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] deadline;
      logic [REP_W-1:0] repeats;
      logic [TAG_W-1:0] tag;
   } slot_entry_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [HANDLE_W-1:0] handle;
      logic [TAG_W-1:0] tag;
      logic success;
      logic last;
   } rsp_type;

endpackage

FILE: hdl/mrt_slot_mem.sv
// Slot memory: one write port and one registered read port.
`timescale 1ns / 1ps

module mrt_slot_mem #(
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic wr_en,
   input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input mrt_pkg::slot_entry_type wr_data,
   input logic rd_en,
   input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output mrt_pkg::slot_entry_type rd_data
);
   import mrt_pkg::*;

   slot_entry_type slot_ram_ff [DEPTH];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/mrt_rsp_reg.sv
// Output register of the response channel.
`timescale 1ns / 1ps

module mrt_rsp_reg (
   input logic clock,
   input logic reset,
   input logic load,
   input mrt_pkg::rsp_type load_data,
   input logic rsp_stall,
   output logic rsp_valid,
   output mrt_pkg::rsp_type rsp_data,
   output logic ready
);
   import mrt_pkg::*;

   logic valid_ff;
   logic valid_in;
   rsp_type data_ff;

   // The register can take a new response when empty or when it drains now.
   assign ready = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

endmodule

FILE: hdl/mrt_ctrl.sv
// Sequencer: live bits, millisecond clock, add/remove and the tick scan.
`timescale 1ns / 1ps

module mrt_ctrl #(
   parameter int SLOT_COUNT = mrt_pkg::SLOT_COUNT_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic [mrt_pkg::OP_W-1:0] req_operation,
   input logic [mrt_pkg::TIME_W-1:0] req_interval_ms,
   input logic [mrt_pkg::REP_W-1:0] req_repeat_count,
   input logic [mrt_pkg::TAG_W-1:0] req_user_tag,
   input logic [mrt_pkg::HANDLE_W-1:0] req_slot_handle,
   output logic req_stall,
   input logic out_ready,
   output logic rsp_load,
   output mrt_pkg::rsp_type rsp_data,
   output logic mem_wr_en,
   output logic [((((SLOT_COUNT > mrt_pkg::MAX_SLOTS) ? mrt_pkg::MAX_SLOTS : SLOT_COUNT) > 1)
      ? $clog2(((SLOT_COUNT > mrt_pkg::MAX_SLOTS) ? mrt_pkg::MAX_SLOTS : SLOT_COUNT))
      : 1)-1:0] mem_wr_addr,
   output mrt_pkg::slot_entry_type mem_wr_data,
   output logic mem_rd_en,
   output logic [((((SLOT_COUNT > mrt_pkg::MAX_SLOTS) ? mrt_pkg::MAX_SLOTS : SLOT_COUNT) > 1)
      ? $clog2(((SLOT_COUNT > mrt_pkg::MAX_SLOTS) ? mrt_pkg::MAX_SLOTS : SLOT_COUNT))
      : 1)-1:0] mem_rd_addr,
   input mrt_pkg::slot_entry_type mem_rd_data
);
   import mrt_pkg::*;

   localparam int SlotUse = (SLOT_COUNT > MAX_SLOTS) ? MAX_SLOTS : SLOT_COUNT;
   localparam int IdxW = (SlotUse > 1) ? $clog2(SlotUse) : 1;
   localparam int CntW = $clog2(SlotUse + 1);

   state_type state_ff, state_in;
   logic [SlotUse-1:0] live_ff, live_in;
   logic [TIME_W-1:0] clock_ff, clock_in;
   logic [CntW-1:0] scan_ff, scan_in;
   logic eval_valid_ff, eval_valid_in;
   logic [IdxW-1:0] eval_idx_ff, eval_idx_in;

   logic accept;
   logic fire;
   logic hold;
   logic scan_end;
   logic free_found;
   logic [IdxW-1:0] free_idx;
   logic handle_ok;

   assign accept = (state_ff == ST_IDLE) && req_valid && out_ready;
   // The slot being evaluated has its entry in the registered read data of the slot memory.
   assign fire = eval_valid_ff && live_ff[eval_idx_ff] && (clock_ff > mem_rd_data.deadline);
   assign hold = fire && !out_ready;
   assign scan_end = (scan_ff == CntW'(SlotUse));
   assign handle_ok = ({1'b0, req_slot_handle} < (HANDLE_W + 1)'(SlotUse))
      && live_ff[req_slot_handle[IdxW-1:0]];

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = SlotUse - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_found = 1'b1;
            free_idx = IdxW'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_TICK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!hold && scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rsp_load = 1'b0;
      rsp_data = '0;
      mem_wr_en = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = mem_rd_data;
      mem_rd_en = 1'b0;
      mem_rd_addr = '0;
      live_in = live_ff;
      clock_in = clock_ff;
      scan_in = scan_ff;
      eval_valid_in = eval_valid_ff;
      eval_idx_in = eval_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !out_ready;
            if (accept) begin
               case (req_operation)
                  OP_ADD: begin
                     rsp_load = 1'b1;
                     rsp_data.kind = KIND_ADD;
                     rsp_data.last = 1'b1;
                     if (free_found) begin
                        live_in[free_idx] = 1'b1;
                        mem_wr_en = 1'b1;
                        mem_wr_addr = free_idx;
                        mem_wr_data.period = req_interval_ms;
                        mem_wr_data.deadline = clock_ff + req_interval_ms;
                        mem_wr_data.repeats = req_repeat_count;
                        mem_wr_data.tag = req_user_tag;
                        rsp_data.handle = HANDLE_W'(free_idx);
                        rsp_data.success = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     rsp_load = 1'b1;
                     rsp_data.kind = KIND_REMOVE;
                     rsp_data.handle = req_slot_handle;
                     rsp_data.success = handle_ok;
                     rsp_data.last = 1'b1;
                     if (handle_ok) begin
                        live_in[req_slot_handle[IdxW-1:0]] = 1'b0;
                     end
                  end
                  OP_TICK: begin
                     clock_in = clock_ff + 1'b1;
                     scan_in = '0;
                     eval_valid_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!hold) begin
               eval_valid_in = 1'b0;
               if (fire) begin
                  rsp_load = 1'b1;
                  rsp_data.kind = KIND_FIRED;
                  rsp_data.handle = HANDLE_W'(eval_idx_ff);
                  rsp_data.tag = mem_rd_data.tag;
                  if (mem_rd_data.repeats == REP_W'(1)) begin
                     live_in[eval_idx_ff] = 1'b0;
                  end else begin
                     mem_wr_en = 1'b1;
                     mem_wr_addr = eval_idx_ff;
                     mem_wr_data.deadline = mem_rd_data.deadline + mem_rd_data.period;
                     if (mem_rd_data.repeats != '0) begin
                        mem_wr_data.repeats = mem_rd_data.repeats - 1'b1;
                     end
                  end
               end
               // Read the next slot while this one is written back.
               if (!scan_end) begin
                  mem_rd_en = 1'b1;
                  mem_rd_addr = scan_ff[IdxW-1:0];
                  eval_valid_in = 1'b1;
                  eval_idx_in = scan_ff[IdxW-1:0];
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (out_ready) begin
               rsp_load = 1'b1;
               rsp_data.kind = KIND_DONE;
               rsp_data.last = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         live_ff <= '0;
         clock_ff <= '0;
         scan_ff <= '0;
         eval_valid_ff <= 1'b0;
         eval_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         live_ff <= live_in;
         clock_ff <= clock_in;
         scan_ff <= scan_in;
         eval_valid_ff <= eval_valid_in;
         eval_idx_ff <= eval_idx_in;
      end
   end

endmodule

FILE: hdl/multi_slot_repeat_timer_unit.sv
// Top level of the multi-slot repeating timer table.
`timescale 1ns / 1ps

// Usage: each request on the req_ channel carries an operation: add a timer,
// remove a timer by its slot handle, or a one millisecond tick. Every request
// except the unused operation code gives one or more responses on the rsp_
// channel, and the last response of each request has rsp_last_of_run set.
// Add and remove give a single response: the response is registered at the edge that
// accepts the request and shows in the following cycle.
// A tick reads one slot per cycle, while no fired response is stalled, through
// the single read port of the slot memory, writes back each fired slot that
// keeps repeating once its entry leaves the registered read port, and then
// gives the done response. One fired response is given per expiring slot, in
// slot order, then the done response.
// The next request is taken once the previous one has issued all its
// responses and the output register can accept a new one.
// Reset clears the live bits of all slots and the millisecond clock.
// While rsp_stall holds back a waiting response, that response stays
// unchanged, req_stall is high, and the scan pauses at the next fired slot.
module multi_slot_repeat_timer_unit #(
   parameter int SLOT_COUNT = mrt_pkg::SLOT_COUNT_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [mrt_pkg::OP_W-1:0] req_operation,
   input logic [mrt_pkg::TIME_W-1:0] req_interval_ms,
   input logic [mrt_pkg::REP_W-1:0] req_repeat_count,
   input logic [mrt_pkg::TAG_W-1:0] req_user_tag,
   input logic [mrt_pkg::HANDLE_W-1:0] req_slot_handle,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [mrt_pkg::KIND_W-1:0] rsp_result_kind,
   output logic [mrt_pkg::HANDLE_W-1:0] rsp_handle_out,
   output logic [mrt_pkg::TAG_W-1:0] rsp_tag_out,
   output logic rsp_success,
   output logic rsp_last_of_run
);
   import mrt_pkg::*;

   localparam int SlotUse = (SLOT_COUNT > MAX_SLOTS) ? MAX_SLOTS : SLOT_COUNT;
   localparam int IdxW = (SlotUse > 1) ? $clog2(SlotUse) : 1;

   logic out_ready;
   logic rsp_load;
   rsp_type load_data;
   rsp_type rsp_data;
   logic mem_wr_en;
   logic [IdxW-1:0] mem_wr_addr;
   slot_entry_type mem_wr_data;
   logic mem_rd_en;
   logic [IdxW-1:0] mem_rd_addr;
   slot_entry_type mem_rd_data;

   mrt_ctrl #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_operation(req_operation),
      .req_interval_ms(req_interval_ms),
      .req_repeat_count(req_repeat_count),
      .req_user_tag(req_user_tag),
      .req_slot_handle(req_slot_handle),
      .req_stall(req_stall),
      .out_ready(out_ready),
      .rsp_load(rsp_load),
      .rsp_data(load_data),
      .mem_wr_en(mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_en(mem_rd_en),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data)
   );

   mrt_slot_mem #(
      .DEPTH(SlotUse)
   ) u_slot_mem (
      .clock(clock),
      .wr_en(mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en(mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   mrt_rsp_reg u_rsp_reg (
      .clock(clock),
      .reset(reset),
      .load(rsp_load),
      .load_data(load_data),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .ready(out_ready)
   );

   assign rsp_result_kind = rsp_data.kind;
   assign rsp_handle_out = rsp_data.handle;
   assign rsp_tag_out = rsp_data.tag;
   assign rsp_success = rsp_data.success;
   assign rsp_last_of_run = rsp_data.last;

endmodule

FILE: hdl/mrt_checker.sv
// Port-level checker of the timer table, bound to the top level.
`timescale 1ns / 1ps

`include "multi_slot_repeat_timer_unit_assert.svh"

module mrt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic [mrt_pkg::OP_W-1:0] req_operation,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [mrt_pkg::KIND_W-1:0] rsp_result_kind,
   input logic [mrt_pkg::HANDLE_W-1:0] rsp_handle_out,
   input logic [mrt_pkg::TAG_W-1:0] rsp_tag_out,
   input logic rsp_success,
   input logic rsp_last_of_run
);
   import mrt_pkg::*;

   // A fired timer never closes a request and never reports success.
   `MSRT_ASSERT_SAME(a_fired_fields, clock, reset,
      rsp_valid && (rsp_result_kind == KIND_FIRED),
      !rsp_success && !rsp_last_of_run, "fired response with success or last set")

   // The done response closes a tick and carries no handle, tag or success.
   `MSRT_ASSERT_SAME(a_done_fields, clock, reset,
      rsp_valid && (rsp_result_kind == KIND_DONE),
      rsp_last_of_run && !rsp_success && (rsp_handle_out == '0) && (rsp_tag_out == '0),
      "done response fields wrong")

   // Add and remove answers are single responses without a tag.
   `MSRT_ASSERT_SAME(a_answer_fields, clock, reset,
      rsp_valid && ((rsp_result_kind == KIND_ADD) || (rsp_result_kind == KIND_REMOVE)),
      rsp_last_of_run && (rsp_tag_out == '0), "add or remove answer fields wrong")

   // A stalled response stays put.
   `MSRT_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_result_kind) && $stable(rsp_handle_out)
         && $stable(rsp_tag_out) && $stable(rsp_success) && $stable(rsp_last_of_run),
      "stalled response changed")

   // An accepted tick is never answered on the very next cycle by its done response.
   `MSRT_ASSERT_NEXT(a_tick_scans, clock, reset,
      req_valid && !req_stall && (req_operation == OP_TICK),
      req_stall && !(rsp_valid && (rsp_result_kind == KIND_DONE) && !$past(rsp_valid)),
      "tick did not start a scan")

endmodule

bind multi_slot_repeat_timer_unit mrt_checker u_mrt_checker (.*);
